// ===== hdl/cursor_sequence_store_macros.svh =====
// ----------------------------------------------------------------------------
// cursor_sequence_store_macros.svh
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_STORE_MACROS_SVH
`define CURSOR_SEQUENCE_STORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CSEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cseq: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CSEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cseq: next-cycle check failed");

`endif

// ===== hdl/cseq_pkg.sv =====
// ----------------------------------------------------------------------------
// cseq_pkg
// Command codes, controller states and the control/status bundles shared by
// the controller and the datapath of the cursor sequence store.
// ----------------------------------------------------------------------------
package cseq_pkg;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_ADVANCE = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_ATTACH  = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DRAIN,
    ST_PUT,
    ST_READ,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch request and its plan
    logic shift_rd;  // read one entry of a shift, its write follows in the next cycle
    logic put;       // store the request word at its slot
    logic load_out;  // capture the result into the output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic plan_shift;  // accepted request moves entries
    logic plan_put;    // accepted request stores a word
    logic put_pend;    // latched request still has a word to store
    logic rem_one;     // last entry of the shift is being read
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

// ===== hdl/cseq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cseq_ctrl
// Sequencer for one request: shift, store, read back, deliver.
// ----------------------------------------------------------------------------
module cseq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cseq_pkg::sts_t  sts,
  output cseq_pkg::ctl_t  ctl
);

  cseq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cseq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    in_ready     = 1'b0;
    case (state_r)
      cseq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (sts.plan_shift) begin
            state_nxt = cseq_pkg::ST_SHIFT;
          end else if (sts.plan_put) begin
            state_nxt = cseq_pkg::ST_PUT;
          end else begin
            state_nxt = cseq_pkg::ST_READ;
          end
        end
      end
      cseq_pkg::ST_SHIFT: begin
        ctl.shift_rd = 1'b1;
        if (sts.rem_one) begin
          state_nxt = cseq_pkg::ST_DRAIN;
        end
      end
      // last shifted entry is written here
      cseq_pkg::ST_DRAIN: begin
        state_nxt = sts.put_pend ? cseq_pkg::ST_PUT : cseq_pkg::ST_READ;
      end
      cseq_pkg::ST_PUT: begin
        ctl.put   = 1'b1;
        state_nxt = cseq_pkg::ST_READ;
      end
      cseq_pkg::ST_READ: begin
        state_nxt = cseq_pkg::ST_DONE;
      end
      cseq_pkg::ST_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = cseq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cseq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cseq_dpath.sv =====
// ----------------------------------------------------------------------------
// cseq_dpath
// Item memory, count and cursor registers, shift address generation and the
// output register.
// ----------------------------------------------------------------------------
module cseq_dpath #(
  parameter int CAPACITY_ITEMS = 32,
  parameter int ITEM_WIDTH     = 32,
  parameter int AW             = $clog2(CAPACITY_ITEMS),
  parameter int CW             = $clog2(CAPACITY_ITEMS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cseq_pkg::ctl_t        ctl,
  output cseq_pkg::sts_t        sts,
  input  logic [2:0]            in_command,
  input  logic [ITEM_WIDTH-1:0] in_entry_value,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [ITEM_WIDTH-1:0] out_current_value,
  output logic                  out_has_item,
  output logic [CW-1:0]         out_item_count,
  output logic                  out_rejected
);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY_ITEMS);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [ITEM_WIDTH-1:0] mem [CAPACITY_ITEMS];

  logic [CW-1:0]         count_r, cursor_r;
  logic [CW-1:0]         src_r, rem_r, pos_r;
  logic                  up_r, put_r, rej_r, pend_r;
  logic [AW-1:0]         wr_addr_r;
  logic [ITEM_WIDTH-1:0] word_r, rd_data_r;
  logic [AW-1:0]         rd_addr;

  logic                  out_valid_r, out_has_r, out_rej_r;
  logic [ITEM_WIDTH-1:0] out_value_r;
  logic [CW-1:0]         out_count_r;

  // plan of the request at the input, from the current count and cursor
  logic          on_item, full;
  logic [CW-1:0] cur_p, cnt_p, src_p, rem_p, pos_p;
  logic          up_p, put_p, rej_p;

  always_comb begin
    on_item = cursor_r < count_r;
    full    = count_r >= CAP_C;
    cur_p   = cursor_r;
    cnt_p   = count_r;
    src_p   = count_r - ONE_C;
    rem_p   = '0;
    pos_p   = cursor_r;
    up_p    = 1'b1;
    put_p   = 1'b0;
    rej_p   = 1'b0;
    case (in_command)
      cseq_pkg::CMD_START: begin
        cur_p = '0;
      end
      cseq_pkg::CMD_ADVANCE: begin
        cur_p = on_item ? cursor_r + ONE_C : count_r;
      end
      cseq_pkg::CMD_INSERT: begin
        if (full) begin
          rej_p = 1'b1;
        end else begin
          pos_p = on_item ? cursor_r : '0;
          cur_p = pos_p;
          rem_p = count_r - pos_p;
          cnt_p = count_r + ONE_C;
          put_p = 1'b1;
        end
      end
      cseq_pkg::CMD_ATTACH: begin
        if (full) begin
          rej_p = 1'b1;
        end else begin
          pos_p = on_item ? cursor_r + ONE_C : count_r;
          cur_p = pos_p;
          rem_p = count_r - pos_p;
          cnt_p = count_r + ONE_C;
          put_p = 1'b1;
        end
      end
      cseq_pkg::CMD_REMOVE: begin
        if (!on_item) begin
          rej_p = 1'b1;
        end else begin
          // entries above the cursor move down one place
          src_p = cursor_r + ONE_C;
          rem_p = count_r - cursor_r - ONE_C;
          up_p  = 1'b0;
          cnt_p = count_r - ONE_C;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.plan_shift = rem_p != '0;
    sts.plan_put   = put_p;
    sts.put_pend   = put_r;
    sts.rem_one    = rem_r == ONE_C;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= ctl.shift_rd;
      if (ctl.accept) begin
        count_r  <= cnt_p;
        cursor_r <= cur_p;
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request plan and shift addressing
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      src_r  <= src_p;
      rem_r  <= rem_p;
      pos_r  <= pos_p;
      up_r   <= up_p;
      put_r  <= put_p;
      rej_r  <= rej_p;
      word_r <= in_entry_value;
    end
    if (ctl.shift_rd) begin
      src_r     <= up_r ? src_r - ONE_C : src_r + ONE_C;
      rem_r     <= rem_r - ONE_C;
      wr_addr_r <= up_r ? src_r[AW-1:0] + AW'(1) : src_r[AW-1:0] - AW'(1);
    end
  end

  // cursor may sit one past the last slot; that read is masked by has_item
  assign rd_addr = ctl.shift_rd ? src_r[AW-1:0] : cursor_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (pend_r) begin
      mem[wr_addr_r] <= rd_data_r;
    end else if (ctl.put) begin
      mem[pos_r[AW-1:0]] <= word_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_has_r   <= on_item;
      out_value_r <= on_item ? rd_data_r : '0;
      out_count_r <= count_r;
      out_rej_r   <= rej_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_value = out_value_r;
  assign out_has_item      = out_has_r;
  assign out_item_count    = out_count_r;
  assign out_rejected      = out_rej_r;

endmodule

// ===== hdl/cursor_sequence_store.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_store
// Ordered list of up to CAPACITY_ITEMS words with a cursor, one result per
// request.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A request that moves no entries goes
// through acceptance, a memory read and the result load before its result
// is offered; one that stores a word adds a store state, and one that shifts
// entries adds a shift state and a drain state, since the item memory moves
// one entry per cycle, each read and then written in the next cycle. The
// output register lets a new request be accepted while the previous result
// is still waiting to be taken. Memory entries start undefined; only entries
// below the count reach the output.
module cursor_sequence_store #(
  parameter int CAPACITY_ITEMS = 32,
  parameter int ITEM_WIDTH     = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            in_command,
  input  logic [ITEM_WIDTH-1:0]                 in_entry_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ITEM_WIDTH-1:0]                 out_current_value,
  output logic                                  out_has_item,
  output logic [$clog2(CAPACITY_ITEMS + 1)-1:0] out_item_count,
  output logic                                  out_rejected
);

  cseq_pkg::ctl_t ctl;
  cseq_pkg::sts_t sts;

  cseq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  cseq_dpath #(
    .CAPACITY_ITEMS (CAPACITY_ITEMS),
    .ITEM_WIDTH     (ITEM_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_command        (in_command),
    .in_entry_value    (in_entry_value),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_current_value (out_current_value),
    .out_has_item      (out_has_item),
    .out_item_count    (out_item_count),
    .out_rejected      (out_rejected)
  );

endmodule

// ===== hdl/cseq_checker.sv =====
// ----------------------------------------------------------------------------
// cseq_checker
// Port-level checks on the cursor sequence store, bound to the top level.
// ----------------------------------------------------------------------------
`include "cursor_sequence_store_macros.svh"

module cseq_checker #(
  parameter int CAPACITY_ITEMS = 32,
  parameter int ITEM_WIDTH     = 32
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [ITEM_WIDTH-1:0]                 out_current_value,
  input logic                                  out_has_item,
  input logic [$clog2(CAPACITY_ITEMS + 1)-1:0] out_item_count,
  input logic                                  out_rejected
);

  localparam int CW = $clog2(CAPACITY_ITEMS + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY_ITEMS);

  // no current item means the value reads as zero
  `CSEQ_ASSERT_IMP(a_empty_zero, out_valid && !out_has_item, out_current_value == '0)
  `CSEQ_ASSERT_IMP(a_count_cap, out_valid, out_item_count <= CAP_C)
  // a reject is either a full store or a remove without a current item
  `CSEQ_ASSERT_IMP(a_reject_cause, out_valid && out_rejected, !out_has_item || out_item_count == CAP_C)
  // one request in flight: the request port closes right after an accept
  `CSEQ_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `CSEQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_current_value))

endmodule

bind cursor_sequence_store cseq_checker #(
  .CAPACITY_ITEMS (CAPACITY_ITEMS),
  .ITEM_WIDTH     (ITEM_WIDTH)
) u_cseq_checker (.*);

// ===== test/cursor_sequence_store_tb.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_store_tb
// Self-checking bench for the cursor sequence store. A queue of requests,
// filled up front with a directed opening and random grow/shrink/mixed
// phases, feeds a clocked driver. A clocked monitor keeps its own copy of the
// list and cursor, predicts each result at request acceptance and checks the
// results in order. Both handshakes idle at random, the receiver holds off
// once for a long stretch; marked requests wait for a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_sequence_store_tb;

  localparam int CAPACITY = 32;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  // codes outside the defined set, handled as a query
  localparam logic [2:0] CODE_SPARE_LO = 3'd6;
  localparam logic [2:0] CODE_SPARE_HI = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  localparam int IDLE_PCT     = 12;
  localparam int RX_HOLD_AT   = 300;
  localparam int RX_HOLD_LEN  = 240;
  localparam int QUIET_FIRST  = 450;
  localparam int QUIET_LAST   = 600;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 60;

  typedef struct {
    logic [2:0]        cmd;
    logic [WORD_W-1:0] word;
    bit                drain_first;  // wait for all outstanding results first
  } request_t;

  typedef struct packed {
    logic [WORD_W-1:0]  value;
    logic               has_item;
    logic [COUNT_W-1:0] count;
    logic               rejected;
  } outcome_t;

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [2:0]          in_command     = cseq_pkg::CMD_QUERY;
  logic [WORD_W-1:0]   in_entry_value = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [WORD_W-1:0]   out_current_value;
  logic                out_has_item;
  logic [COUNT_W-1:0]  out_item_count;
  logic                out_rejected;

  request_t pending_q[$];
  outcome_t expected_q[$];

  int accepted_cnt = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  // shadow copy of the list and cursor
  logic [WORD_W-1:0] list_words [CAPACITY];
  int                list_len    = 0;
  int                list_cursor = 0;

  wire quiet_tx = (accepted_cnt >= QUIET_FIRST) && (accepted_cnt < QUIET_LAST);
  wire quiet_rx = (results_seen >= QUIET_FIRST) && (results_seen < QUIET_LAST);

  cursor_sequence_store #(
    .CAPACITY_ITEMS(CAPACITY),
    .ITEM_WIDTH    (WORD_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_entry_value   (in_entry_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_current_value(out_current_value),
    .out_has_item     (out_has_item),
    .out_item_count   (out_item_count),
    .out_rejected     (out_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one request to the shadow list and returns the result it causes.
  function automatic outcome_t apply_command(logic [2:0] cmd, logic [WORD_W-1:0] word);
    outcome_t res;
    bit       on_item;
    res     = '0;
    on_item = list_cursor < list_len;
    case (cmd)
      cseq_pkg::CMD_START: begin
        list_cursor = 0;
      end
      cseq_pkg::CMD_ADVANCE: begin
        list_cursor = on_item ? list_cursor + 1 : list_len;
      end
      cseq_pkg::CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.rejected = 1'b1;
        end else begin
          if (!on_item) list_cursor = 0;
          for (int i = list_len; i > list_cursor; i--) list_words[i] = list_words[i-1];
          list_words[list_cursor] = word;
          list_len++;
        end
      end
      cseq_pkg::CMD_ATTACH: begin
        if (list_len >= CAPACITY) begin
          res.rejected = 1'b1;
        end else begin
          if (!on_item) begin
            list_cursor = list_len;
          end else begin
            list_cursor++;
            for (int i = list_len; i > list_cursor; i--) list_words[i] = list_words[i-1];
          end
          list_words[list_cursor] = word;
          list_len++;
        end
      end
      cseq_pkg::CMD_REMOVE: begin
        if (!on_item) begin
          res.rejected = 1'b1;
        end else begin
          for (int i = list_cursor + 1; i < list_len; i++) list_words[i-1] = list_words[i];
          list_len--;
        end
      end
      default: ;
    endcase
    if (list_cursor < list_len) begin
      res.value    = list_words[list_cursor];
      res.has_item = 1'b1;
    end
    res.count = list_len[COUNT_W-1:0];
    return res;
  endfunction

  task automatic queue_request(logic [2:0] cmd, logic [WORD_W-1:0] word, bit drain = 1'b0);
    request_t req;
    req.cmd         = cmd;
    req.word        = word;
    req.drain_first = drain;
    pending_q.push_back(req);
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // Weighted command choice: start, advance, insert, attach, remove, query, spare.
  function automatic logic [2:0] random_command(int mode);
    int weights[7];
    int roll;
    case (mode)
      MODE_GROW:   weights = '{5, 10, 35, 35, 5, 5, 5};
      MODE_SHRINK: weights = '{10, 15, 5, 5, 55, 5, 5};
      default:     weights = '{15, 25, 15, 15, 15, 10, 5};
    endcase
    roll = $urandom_range(99);
    for (int k = 0; k < 7; k++) begin
      if (roll < weights[k]) begin
        if (k == 6) return $urandom_range(1) ? CODE_SPARE_HI : CODE_SPARE_LO;
        return 3'(k);
      end
      roll -= weights[k];
    end
    return cseq_pkg::CMD_QUERY;
  endfunction

  task automatic report_mismatch(string what, outcome_t want, outcome_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] %s: expected value=%h has=%0b count=%0d rej=%0b",
               $realtime, what, want.value, want.has_item, want.count, want.rejected);
      $display("    got value=%h has=%0b count=%0d rej=%0b",
               got.value, got.has_item, got.count, got.rejected);
    end
  endtask

  // Request driver.
  always @(posedge clk) begin : driver
    request_t req;
    bit       taken;
    taken = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) accepted_cnt <= accepted_cnt + 1;
      if (in_valid && !in_ready) begin
        // hold the offered request
      end else if (pending_q.size() != 0 &&
                   (quiet_tx || $urandom_range(99) >= IDLE_PCT) &&
                   (!pending_q[0].drain_first || accepted_cnt + taken == results_seen)) begin
        req = pending_q.pop_front();
        in_valid       <= 1'b1;
        in_command     <= req.cmd;
        in_entry_value <= req.word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result ready, with one long hold-off once traffic is under way.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= RX_HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= RX_HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_ready <= quiet_rx || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Checks results first, then predicts for a request taken at this edge.
  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.value    = out_current_value;
        got.has_item = out_has_item;
        got.count    = out_item_count;
        got.rejected = out_rejected;
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value)       report_mismatch("current_value", want, got);
          if (got.has_item !== want.has_item) report_mismatch("has_item", want, got);
          if (got.count !== want.count)       report_mismatch("item_count", want, got);
          if (got.rejected !== want.rejected) report_mismatch("rejected", want, got);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(apply_command(in_command, in_entry_value));
    end
  end

  initial begin : stimulus
    int mode;
    int span;
    int issued;
    int phase;

    // directed opening: empty store, front/end placement, spare codes, removal off the end
    queue_request(cseq_pkg::CMD_QUERY, '0);
    queue_request(cseq_pkg::CMD_ADVANCE, '0);
    queue_request(cseq_pkg::CMD_REMOVE, '0);
    queue_request(cseq_pkg::CMD_START, '0);
    queue_request(cseq_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    queue_request(cseq_pkg::CMD_ATTACH, 32'h0000_0000);
    queue_request(cseq_pkg::CMD_ADVANCE, '0);
    queue_request(cseq_pkg::CMD_ATTACH, 32'hA5A5_A5A5);
    queue_request(cseq_pkg::CMD_START, '0);
    queue_request(cseq_pkg::CMD_INSERT, 32'h0000_0001);
    queue_request(CODE_SPARE_LO, 32'h1234_5678);
    queue_request(CODE_SPARE_HI, 32'h8765_4321);
    queue_request(cseq_pkg::CMD_ADVANCE, '0);
    queue_request(cseq_pkg::CMD_REMOVE, '0);
    queue_request(cseq_pkg::CMD_ADVANCE, '0);
    queue_request(cseq_pkg::CMD_ADVANCE, '0);
    queue_request(cseq_pkg::CMD_REMOVE, '0);
    queue_request(cseq_pkg::CMD_QUERY, '0);
    queue_request(cseq_pkg::CMD_INSERT, 32'h8000_0000);
    queue_request(cseq_pkg::CMD_ADVANCE, '0);
    queue_request(cseq_pkg::CMD_ADVANCE, '0);
    queue_request(cseq_pkg::CMD_REMOVE, '0);
    queue_request(cseq_pkg::CMD_START, '0, 1'b1);

    // random phases; grow phases run the store into full often
    issued = 0;
    phase  = 0;
    while (issued < 880) begin
      mode = (phase % 3 == 2) ? MODE_MIXED : ((phase % 3 == 0) ? MODE_GROW : MODE_SHRINK);
      span = $urandom_range(40, 90);
      for (int k = 0; k < span; k++) begin
        queue_request(random_command(mode), random_word(), (k == 0) && (phase % 5 == 3));
      end
      issued += span;
      phase++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(negedge clk);
    while (results_seen != accepted_cnt) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
